### hw/rtl/lfbs_pkg.sv
package lfbs_pkg;

    localparam int JOB_DEPTH_DEFAULT = 2;

    localparam logic [7:0] STUFF_MASK   = 8'h20;
    localparam logic [7:0] FLAG_RESET   = 8'h7E;
    localparam logic [7:0] ESCAPE_RESET = 8'h7D;

    localparam logic CMD_SUPERVISORY = 1'b0;
    localparam logic CMD_INFO        = 1'b1;

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_FLAG   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE = 1'd1;

    // byte slots of one job, in line order
    localparam int SLOT_OPEN      = 0;
    localparam int SLOT_ADDR      = 1;
    localparam int SLOT_CTRL      = 2;
    localparam int SLOT_HCHK      = 3;
    localparam int SLOT_DATA_ESC  = 4;
    localparam int SLOT_DATA      = 5;
    localparam int SLOT_CHECK_ESC = 6;
    localparam int SLOT_CHECK     = 7;
    localparam int SLOT_CLOSE     = 8;
    localparam int NUM_SLOTS      = 9;

    typedef logic [NUM_SLOTS-1:0] slot_mask_t;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
        logic [7:0] address_byte;
        logic [7:0] control_byte;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       frame_end;
    } out_item_t;

    typedef struct packed {
        logic [7:0] flag_byte;
        logic [7:0] escape_byte;
    } cfg_t;

    // data and check already carry the xor when stuffed
    typedef struct packed {
        slot_mask_t slots;
        logic [7:0] address_byte;
        logic [7:0] control_byte;
        logic [7:0] data_val;
        logic [7:0] check_val;
    } job_t;

    typedef struct packed {
        logic active;
        logic take;
    } bk_status_t;

endpackage

### hw/rtl/lfbs_front.sv
module lfbs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  lfbs_pkg::in_item_t item,
    input  lfbs_pkg::cfg_t    cfg,
    output lfbs_pkg::job_t    job
);
    import lfbs_pkg::*;

    logic [7:0] check_reg, check_next;
    logic       inside_reg, inside_next;

    logic       hdr;
    logic [7:0] check_base;
    logic [7:0] new_check;
    logic       data_stuff;
    logic       check_stuff;

    always_comb
    begin
        hdr         = (item.command == CMD_SUPERVISORY) || item.first_byte || !inside_reg;
        check_base  = hdr ? 8'h00 : check_reg;
        new_check   = check_base ^ item.data_byte;
        data_stuff  = (item.data_byte == cfg.flag_byte) || (item.data_byte == cfg.escape_byte);
        check_stuff = (new_check == cfg.flag_byte) || (new_check == cfg.escape_byte);

        job.address_byte = item.address_byte;
        job.control_byte = item.control_byte;
        job.data_val     = data_stuff ? (item.data_byte ^ STUFF_MASK) : item.data_byte;
        job.check_val    = check_stuff ? (new_check ^ STUFF_MASK) : new_check;

        job.slots            = '0;
        job.slots[SLOT_OPEN] = hdr;
        job.slots[SLOT_ADDR] = hdr;
        job.slots[SLOT_CTRL] = hdr;
        job.slots[SLOT_HCHK] = hdr;
        if (item.command == CMD_SUPERVISORY)
        begin
            job.slots[SLOT_CLOSE] = 1'b1;
            check_next  = 8'h00;
            inside_next = 1'b0;
        end
        else
        begin
            job.slots[SLOT_DATA_ESC]  = data_stuff;
            job.slots[SLOT_DATA]      = 1'b1;
            job.slots[SLOT_CHECK_ESC] = item.last_byte && check_stuff;
            job.slots[SLOT_CHECK]     = item.last_byte;
            job.slots[SLOT_CLOSE]     = item.last_byte;
            check_next  = item.last_byte ? 8'h00 : new_check;
            inside_next = !item.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_reg  <= 8'h00;
            inside_reg <= 1'b0;
        end
        else if (accept)
        begin
            check_reg  <= check_next;
            inside_reg <= inside_next;
        end
    end

endmodule

### hw/rtl/lfbs_queue.sv
module lfbs_queue #(
    parameter int DEPTH = lfbs_pkg::JOB_DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lfbs_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output lfbs_pkg::job_t head_job,
    output logic           empty
);
    import lfbs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    job_t          entries [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = entries[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
    end

endmodule

### hw/rtl/lfbs_back.sv
module lfbs_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lfbs_pkg::cfg_t       cfg,
    input  lfbs_pkg::job_t       head_job,
    input  logic                 head_empty,
    output lfbs_pkg::bk_status_t status,
    input  logic                 pop,
    output logic                 empty,
    output lfbs_pkg::out_item_t  pop_item
);
    import lfbs_pkg::*;

    job_t       job_reg;
    slot_mask_t slots_reg;
    slot_mask_t slots_after;
    logic       out_valid_reg;
    out_item_t  out_reg;

    logic       active;
    logic       adv;
    logic       take;
    logic [7:0] next_byte;
    logic       next_close;

    assign active      = |slots_reg;
    assign adv         = active && (!out_valid_reg || pop);
    // clear the lowest pending slot
    assign slots_after = slots_reg & (slots_reg - slot_mask_t'(1));
    assign take        = !head_empty && (!active || (adv && (slots_after == '0)));

    assign status.active = active;
    assign status.take   = take;
    assign empty         = !out_valid_reg;
    assign pop_item      = out_reg;

    always_comb
    begin
        next_close = 1'b0;
        priority if (slots_reg[SLOT_OPEN])
            next_byte = cfg.flag_byte;
        else if (slots_reg[SLOT_ADDR])
            next_byte = job_reg.address_byte;
        else if (slots_reg[SLOT_CTRL])
            next_byte = job_reg.control_byte;
        else if (slots_reg[SLOT_HCHK])
            next_byte = job_reg.address_byte ^ job_reg.control_byte;
        else if (slots_reg[SLOT_DATA_ESC])
            next_byte = cfg.escape_byte;
        else if (slots_reg[SLOT_DATA])
            next_byte = job_reg.data_val;
        else if (slots_reg[SLOT_CHECK_ESC])
            next_byte = cfg.escape_byte;
        else if (slots_reg[SLOT_CHECK])
            next_byte = job_reg.check_val;
        else
        begin
            next_byte  = cfg.flag_byte;
            next_close = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            job_reg <= head_job;
        if (adv)
        begin
            out_reg.out_byte  <= next_byte;
            out_reg.run_end   <= (slots_after == '0);
            out_reg.frame_end <= next_close;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                slots_reg <= head_job.slots;
            else if (adv)
                slots_reg <= slots_after;

            if (adv)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

### hw/rtl/link_frame_builder_stuffer_core.sv
// Channel  Handshake          Payload
// -------  -----------------  ----------------------------------------
// input    push / full        push_item (in_item_t)
// result   pop / empty        pop_item (out_item_t)
// config   cfg_write_en       cfg_index, cfg_data (flag, escape)
//
// The byte sequencer sends one result byte per cycle while results are popped;
// an item causes 1 or 2 result bytes mid-frame, up to 9 for a one-byte frame.
// Items are classified on transfer and wait in a JOB_DEPTH job queue.
// Reset: flag 0x7E, escape 0x7D, no frame open, job queue and result register empty.
// A withheld pop stalls the sequencer; full rises only when the job queue fills.
module link_frame_builder_stuffer_core #(
    parameter int JOB_DEPTH = lfbs_pkg::JOB_DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  lfbs_pkg::in_item_t               push_item,
    output logic                             empty,
    input  logic                             pop,
    output lfbs_pkg::out_item_t              pop_item,
    input  logic                             cfg_write_en,
    input  logic [lfbs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_data
);
    import lfbs_pkg::*;

    cfg_t       cfg_reg;
    job_t       front_job;
    job_t       head_job;
    logic       q_empty;
    logic       accept;
    bk_status_t bk_status;

    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_byte   <= FLAG_RESET;
            cfg_reg.escape_byte <= ESCAPE_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_FLAG:   cfg_reg.flag_byte   <= cfg_data;
                REG_ESCAPE: cfg_reg.escape_byte <= cfg_data;
            endcase
        end
    end

    lfbs_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (push_item),
        .cfg    (cfg_reg),
        .job    (front_job)
    );

    lfbs_queue #(
        .DEPTH (JOB_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (front_job),
        .full     (full),
        .pop      (bk_status.take),
        .head_job (head_job),
        .empty    (q_empty)
    );

    lfbs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_job   (head_job),
        .head_empty (q_empty),
        .status     (bk_status),
        .pop        (pop),
        .empty      (empty),
        .pop_item   (pop_item)
    );

`ifndef SYNTHESIS
    // closing flag is always the last byte of its item
    a_close_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop_item.frame_end) |-> pop_item.run_end)
        else $error("closing flag without run_end");

    a_close_is_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop_item.frame_end) |-> (pop_item.out_byte == cfg_reg.flag_byte))
        else $error("closing byte differs from flag");

    // pending slots with a free output register must produce a byte
    a_no_idle_output: assert property (@(posedge clk) disable iff (!rst_n)
        (bk_status.active && empty) |=> !empty)
        else $error("sequencer stalled with free output");
`endif

endmodule

### test/tb.sv
module tb;
    import lfbs_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 250;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    in_item_t    push_item = '0;
    logic        empty;
    logic        pop = 1'b0;
    out_item_t   pop_item;
    logic        cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    link_frame_builder_stuffer_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .push_item    (push_item),
        .empty        (empty),
        .pop          (pop),
        .pop_item     (pop_item),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // framer state as seen from the line
    logic [7:0] m_flag = FLAG_RESET;
    logic [7:0] m_escape = ESCAPE_RESET;
    logic [7:0] m_check = 8'h00;
    logic       m_in_frame = 1'b0;

    in_item_t   tx_items[$];
    out_item_t  line_expect[$];
    out_item_t  burst[0:NUM_SLOTS-1];
    int         burst_len;

    int         error_count = 0;
    int         items_sent = 0;
    int         bytes_checked = 0;
    int         settings_used = 1;
    int         stall_cycles = 0;
    int         hold_left = 0;
    logic       hold_done = 1'b0;
    logic       no_idle = 1'b0;
    out_item_t  want_item;

    function automatic void emit(input logic [7:0] b, input logic closing);
        out_item_t o;
        o.out_byte = b;
        o.run_end = 1'b0;
        o.frame_end = closing;
        burst[burst_len] = o;
        burst_len++;
    endfunction

    function automatic void emit_stuffed(input logic [7:0] b);
        if (b == m_flag || b == m_escape)
        begin
            emit(m_escape, 1'b0);
            emit(b ^ STUFF_MASK, 1'b0);
        end
        else
        begin
            emit(b, 1'b0);
        end
    endfunction

    function automatic void emit_header(input logic [7:0] addr, input logic [7:0] ctrl);
        emit(m_flag, 1'b0);
        emit(addr, 1'b0);
        emit(ctrl, 1'b0);
        emit(addr ^ ctrl, 1'b0);
    endfunction

    function automatic void build_line_bytes(input in_item_t it);
        out_item_t o;
        burst_len = 0;
        if (it.command == CMD_SUPERVISORY)
        begin
            m_check = 8'h00;
            m_in_frame = 1'b0;
            emit_header(it.address_byte, it.control_byte);
            emit(m_flag, 1'b1);
        end
        else
        begin
            if (it.first_byte || !m_in_frame)
            begin
                m_check = 8'h00;
                m_in_frame = 1'b1;
                emit_header(it.address_byte, it.control_byte);
            end
            m_check = m_check ^ it.data_byte;
            emit_stuffed(it.data_byte);
            if (it.last_byte)
            begin
                emit_stuffed(m_check);
                emit(m_flag, 1'b1);
                m_check = 8'h00;
                m_in_frame = 1'b0;
            end
        end
        for (int i = 0; i < burst_len; i++)
        begin
            o = burst[i];
            o.run_end = (i == burst_len - 1);
            line_expect.push_back(o);
        end
    endfunction

    function automatic in_item_t mk(input logic cmd, input logic [7:0] data,
                                    input logic [7:0] addr, input logic [7:0] ctrl,
                                    input logic first, input logic last);
        in_item_t it;
        it.command = cmd;
        it.data_byte = data;
        it.address_byte = addr;
        it.control_byte = ctrl;
        it.first_byte = first;
        it.last_byte = last;
        return it;
    endfunction

    function automatic in_item_t mk_random();
        return mk(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  1'($urandom), 1'($urandom));
    endfunction

    // bias payload toward bytes that need stuffing, in data and in the check
    function automatic logic [7:0] pick_payload(input logic [7:0] run);
        logic [7:0] b;
        case ($urandom_range(19))
            0, 1, 2, 3: b = m_flag;
            4, 5:       b = m_escape;
            6:          b = run ^ m_flag;
            7:          b = run ^ m_escape;
            default:    b = 8'($urandom);
        endcase
        return b;
    endfunction

    task automatic gen_traffic(input int count);
        int made;
        int len;
        logic cut;
        logic [7:0] run;
        in_item_t it;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(99) < 15)
            begin
                it = mk_random();
                tx_items.push_back(it);
                made++;
            end
            else
            begin
                len = $urandom_range(1, 6);
                cut = ($urandom_range(9) == 0);
                run = 8'h00;
                for (int k = 0; k < len && made < count; k++)
                begin
                    it = mk_random();
                    it.command = CMD_INFO;
                    it.data_byte = pick_payload(run);
                    it.first_byte = (k == 0);
                    it.last_byte = (k == len - 1) && !cut;
                    run = run ^ it.data_byte;
                    tx_items.push_back(it);
                    made++;
                end
            end
        end
    endtask

    task automatic drain();
        while (tx_items.size() != 0 || push || line_expect.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_framing(input logic [7:0] flag_val, input logic [7:0] esc_val);
        cfg_write_en <= 1'b1;
        cfg_index <= REG_FLAG;
        cfg_data <= flag_val;
        @(posedge clk);
        cfg_index <= REG_ESCAPE;
        cfg_data <= esc_val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        m_flag = flag_val;
        m_escape = esc_val;
        settings_used++;
    endtask

    // sender: holds an offered item until it transfers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                build_line_bytes(push_item);
                void'(tx_items.pop_front());
                items_sent++;
            end
            if (push && full)
            begin
                push <= 1'b1;
            end
            else if (tx_items.size() != 0 && (no_idle || $urandom_range(99) >= 30))
            begin
                push <= 1'b1;
                push_item <= tx_items[0];
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (line_expect.size() == 0)
                begin
                    error_count++;
                    $display("%0t unexpected byte: expected none, got byte %02h",
                             $time, pop_item.out_byte,
                             " run_end %b frame_end %b",
                             pop_item.run_end, pop_item.frame_end);
                end
                else
                begin
                    want_item = line_expect.pop_front();
                    if (pop_item.out_byte !== want_item.out_byte ||
                        pop_item.run_end !== want_item.run_end ||
                        pop_item.frame_end !== want_item.frame_end)
                    begin
                        error_count++;
                        $display("%0t mismatch: expected byte %02h run_end %b frame_end %b,",
                                 $time, want_item.out_byte, want_item.run_end,
                                 want_item.frame_end,
                                 " got byte %02h run_end %b frame_end %b",
                                 pop_item.out_byte, pop_item.run_end,
                                 pop_item.frame_end);
                    end
                end
                bytes_checked++;
            end
            // one long hold-off so the job queue fills and full rises
            if (!hold_done && bytes_checked >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= no_idle || ($urandom_range(99) >= 30);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL link_frame_builder_stuffer_core");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset framing: supervisory extremes, stuffing, restarts and aborts
        tx_items.push_back(mk(CMD_SUPERVISORY, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b1));
        tx_items.push_back(mk(CMD_SUPERVISORY, 8'h00, 8'hFF, 8'hFF, 1'b0, 1'b0));
        tx_items.push_back(mk(CMD_INFO, 8'h7E, 8'h12, 8'h34, 1'b1, 1'b1));
        tx_items.push_back(mk(CMD_INFO, 8'h7D, 8'h7E, 8'h7D, 1'b1, 1'b1));
        tx_items.push_back(mk(CMD_INFO, 8'h00, 8'hA5, 8'h5A, 1'b1, 1'b0));
        tx_items.push_back(mk(CMD_INFO, 8'hFF, 8'h3C, 8'hC3, 1'b0, 1'b0));
        tx_items.push_back(mk(CMD_INFO, 8'h7D, 8'hFF, 8'h00, 1'b0, 1'b0));
        // check comes out equal to the flag
        tx_items.push_back(mk(CMD_INFO, 8'hFC, 8'h00, 8'hFF, 1'b0, 1'b1));
        // payload with no frame open
        tx_items.push_back(mk(CMD_INFO, 8'h7E, 8'h01, 8'h02, 1'b0, 1'b0));
        // restart while a frame is open
        tx_items.push_back(mk(CMD_INFO, 8'h11, 8'h03, 8'h04, 1'b1, 1'b0));
        tx_items.push_back(mk(CMD_INFO, 8'h22, 8'h55, 8'hAA, 1'b0, 1'b0));
        // supervisory aborts the open frame
        tx_items.push_back(mk(CMD_SUPERVISORY, 8'h7E, 8'h80, 8'h01, 1'b0, 1'b1));
        tx_items.push_back(mk(CMD_INFO, 8'h7D, 8'h10, 8'h20, 1'b0, 1'b1));
        tx_items.push_back(mk(CMD_INFO, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
        tx_items.push_back(mk(CMD_INFO, 8'hFF, 8'hFF, 8'h7E, 1'b1, 1'b1));
        tx_items.push_back(mk(CMD_INFO, 8'h20, 8'h7E, 8'h00, 1'b1, 1'b0));
        tx_items.push_back(mk(CMD_INFO, 8'h5D, 8'h00, 8'h7E, 1'b0, 1'b1));
        drain();

        gen_traffic(130);
        drain();

        // extremes, both sides without idle cycles
        set_framing(8'h00, 8'hFF);
        no_idle = 1'b1;
        gen_traffic(110);
        drain();
        no_idle = 1'b0;

        // flag and escape equal
        set_framing(8'h55, 8'h55);
        tx_items.push_back(mk(CMD_INFO, 8'h55, 8'h55, 8'h55, 1'b1, 1'b1));
        tx_items.push_back(mk(CMD_SUPERVISORY, 8'h55, 8'h55, 8'h00, 1'b1, 1'b0));
        tx_items.push_back(mk(CMD_INFO, 8'h75, 8'h01, 8'h54, 1'b1, 1'b0));
        tx_items.push_back(mk(CMD_INFO, 8'h20, 8'h02, 8'h03, 1'b0, 1'b1));
        gen_traffic(100);
        drain();

        set_framing(8'hFF, 8'h00);
        gen_traffic(110);
        drain();

        repeat (20) @(posedge clk);
        $display("covered %0d input items and %0d line bytes across %0d framing settings",
                 items_sent, bytes_checked, settings_used);
        $display("included one-byte frames, aborts, restarts and a long receiver hold-off");
        if (error_count == 0)
            $display("PASS link_frame_builder_stuffer_core");
        else
            $display("FAIL link_frame_builder_stuffer_core");
        $finish;
    end

endmodule
